// ----- src/pressure_sensor_compensation_core_macros.svh -----
// Assertion macros used by the checker file of the compensation core.
// Plain text only; no dependencies.
`ifndef PRESSURE_SENSOR_COMPENSATION_CORE_MACROS_SVH
`define PRESSURE_SENSOR_COMPENSATION_CORE_MACROS_SVH

// Same-cycle implication, off while in reset.
`define PSCC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("pscc assertion failed");

// Next-cycle implication, off while in reset.
`define PSCC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("pscc assertion failed");

// Next-cycle implication that also holds across reset.
`define PSCC_ASSERT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pscc assertion failed");

`endif

// ----- src/pscc_pkg.sv -----
// Shared types and constants of the pressure compensation core.
// No dependencies; every module and interface file imports this package.
package pscc_pkg;

  localparam int RAW_W     = 24;
  localparam int CAL_W     = 16;
  localparam int TEMP_W    = 19;
  localparam int PRES_W    = 26;
  localparam int CFG_IDX_W = 3;
  localparam int DT_W      = 25;
  localparam int DD_W      = 18;

  localparam int QUEUE_DEPTH_DEF = 4;

  // 20.00 C reference and the offset that moves the -15.00 C edge onto dd
  localparam int TEMP_REF     = 2000;
  localparam int FRIGID_REF   = 1500;
  localparam int FRIGID_LIMIT = -(TEMP_REF + FRIGID_REF);

  localparam int TEMP_MIN = -262144;
  localparam int TEMP_MAX = 262143;
  localparam int PRES_MIN = -33554432;
  localparam int PRES_MAX = 33554431;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BAND_HOT,
    BAND_COLD,
    BAND_FRIGID
  } band_t;

  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } cal_t;

  typedef struct packed {
    logic signed [DT_W-1:0] dt;
    logic signed [DD_W-1:0] dd;
    logic [RAW_W-1:0]       d1;
    band_t                  band;
  } task_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- src/pscc_in_if.sv -----
// Input channel of the compensation core: raw temperature and pressure pair.
// Depends on pscc_pkg.
interface pscc_in_if;
  import pscc_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_temperature;
  logic [RAW_W-1:0] raw_pressure;

  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

// ----- src/pscc_out_if.sv -----
// Result channel of the compensation core: compensated temperature and pressure.
// Depends on pscc_pkg.
interface pscc_out_if;
  import pscc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_centi;
  logic signed [PRES_W-1:0] pressure_value;

  modport source (output valid, output temperature_centi, output pressure_value, input ready);
  modport sink   (input valid, input temperature_centi, input pressure_value, output ready);
endinterface

// ----- src/pscc_cfg.sv -----
// Calibration word registers, written through the plain cfg write port.
// Depends on pscc_pkg.
module pscc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pscc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pscc_pkg::CAL_W-1:0]     cfg_data,
  output pscc_pkg::cal_t                 cal
);
  import pscc_pkg::*;

  cal_t cal_r;
  cal_t cal_nxt;

  always_comb begin
    cal_nxt = cal_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_C1:  cal_nxt.c1 = cfg_data;
        REG_C2:  cal_nxt.c2 = cfg_data;
        REG_C3:  cal_nxt.c3 = cfg_data;
        REG_C4:  cal_nxt.c4 = cfg_data;
        REG_C5:  cal_nxt.c5 = cfg_data;
        REG_C6:  cal_nxt.c6 = cfg_data;
        default: cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  assign cal = cal_r;

endmodule

// ----- src/pscc_front.sv -----
// Front end: accepts raw pairs, forms dT and first-order temperature,
// sorts each transaction into its correction band. Depends on pscc_pkg.
module pscc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  pscc_pkg::cal_t    cal,
  pscc_in_if.sink           in_ch,
  input  pscc_pkg::q_stat_t q_stat,
  output logic              push,
  output pscc_pkg::task_t   push_data
);
  import pscc_pkg::*;

  localparam int TPROD_W = DT_W + CAL_W + 1;
  localparam int T_SHIFT = 23;

  logic                      en;
  logic                      v1_r;
  logic                      v2_r;
  logic signed [DT_W-1:0]    dt1_r;
  logic signed [DT_W-1:0]    dt2_r;
  logic [RAW_W-1:0]          d1_1_r;
  logic [RAW_W-1:0]          d1_2_r;
  logic signed [TPROD_W-1:0] tprod_r;
  logic signed [DT_W-1:0]    dt_nxt;
  logic signed [TPROD_W-1:0] tprod_nxt;
  logic signed [DD_W-1:0]    dd;
  band_t                     band;

  // hold the pipe only when a finished transaction cannot enter the queue
  assign en          = !(v2_r && q_stat.full);
  assign in_ch.ready = en;

  assign dt_nxt    = $signed({1'b0, in_ch.raw_temperature}) - $signed({1'b0, cal.c5, 8'b0});
  assign tprod_nxt = dt1_r * $signed({1'b0, cal.c6});

  assign dd = tprod_r[T_SHIFT +: DD_W];

  always_comb begin
    if (dd >= 0) begin
      band = BAND_HOT;
    end else if (dd < FRIGID_LIMIT) begin
      band = BAND_FRIGID;
    end else begin
      band = BAND_COLD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dt1_r   <= dt_nxt;
      d1_1_r  <= in_ch.raw_pressure;
      dt2_r   <= dt1_r;
      d1_2_r  <= d1_1_r;
      tprod_r <= tprod_nxt;
    end
  end

  assign push           = v2_r && en;
  assign push_data.dt   = dt2_r;
  assign push_data.dd   = dd;
  assign push_data.d1   = d1_2_r;
  assign push_data.band = band;

endmodule

// ----- src/pscc_queue.sv -----
// Short queue of classified transactions between front and back end.
// Depends on pscc_pkg.
module pscc_queue #(
  parameter int DEPTH = pscc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pscc_pkg::task_t   push_data,
  input  logic              pop,
  output pscc_pkg::task_t   head,
  output pscc_pkg::q_stat_t q_stat
);
  import pscc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  task_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign q_stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head = mem_r[rd_ptr_r];

endmodule

// ----- src/pscc_back.sv -----
// Back end: second-order corrections, offset and sensitivity, pressure
// product and the two truncating divides, then saturation. Depends on pscc_pkg.
module pscc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  pscc_pkg::cal_t    cal,
  input  pscc_pkg::task_t   head,
  input  pscc_pkg::q_stat_t q_stat,
  output logic              pop,
  pscc_out_if.source        out_ch
);
  import pscc_pkg::*;

  localparam int NSTG     = 8;
  localparam int DT2_W    = 48;
  localparam int DD2_W    = 35;
  localparam int E_W      = DD_W + 1;
  localparam int E2_W     = 35;
  localparam int MUL_W    = DT_W + CAL_W + 1;
  localparam int T2_W     = 17;
  localparam int OFF2A_W  = 36;
  localparam int SENS2A_W = 35;
  localparam int BASE_W   = 37;
  localparam int OFF2_W   = 38;
  localparam int SENS2_W  = 37;
  localparam int OP_W     = 40;
  localparam int SPLIT    = 20;
  localparam int PLO_W    = SPLIT + RAW_W;
  localparam int PHI_W    = OP_W - SPLIT + RAW_W + 1;
  localparam int PROD_W   = 64;
  localparam int P_SHIFT  = 21;
  localparam int Q1_W     = PROD_W - P_SHIFT;
  localparam int DIFF_W   = Q1_W + 1;
  localparam int O_SHIFT  = 15;
  localparam int Q2_W     = DIFF_W - O_SHIFT;

  logic                en;
  logic [NSTG-1:0]     vld_r;
  logic                out_valid_r;

  // stage 1: squares and coefficient products
  logic signed [2*DT_W-1:0] dt2_full;
  logic signed [2*DD_W-1:0] dd2_full;
  logic signed [E_W-1:0]    e_nxt;
  logic signed [MUL_W-1:0]  offt_nxt;
  logic signed [MUL_W-1:0]  senst_nxt;
  logic [DT2_W-1:0]         s1_dt2_r;
  logic [DD2_W-1:0]         s1_dd2_r;
  logic signed [E_W-1:0]    s1_e_r;
  logic signed [MUL_W-1:0]  s1_offt_r;
  logic signed [MUL_W-1:0]  s1_senst_r;
  logic signed [DD_W-1:0]   s1_dd_r;
  band_t                    s1_band_r;
  logic [RAW_W-1:0]         s1_d1_r;

  // stage 2: temperature, band terms, bases
  logic signed [2*E_W-1:0]  e2_full;
  logic [T2_W-1:0]          t2_cold;
  logic [DT2_W+2:0]         dt2x7;
  logic [T2_W-1:0]          t2;
  logic signed [TEMP_W-1:0] temp;
  logic signed [TEMP_W:0]   tf_full;
  logic signed [TEMP_W-1:0] tf_nxt;
  logic [DD2_W+1:0]         dd2x3;
  logic [DD2_W+2:0]         dd2x5;
  logic [OFF2A_W-1:0]       off2a_nxt;
  logic [SENS2A_W-1:0]      sens2a_nxt;
  logic signed [BASE_W-1:0] offb_nxt;
  logic signed [BASE_W-1:0] sensb_nxt;
  logic [E2_W-1:0]          s2_e2_r;
  logic signed [TEMP_W-1:0] s2_tf_r;
  logic [OFF2A_W-1:0]       s2_off2a_r;
  logic [SENS2A_W-1:0]      s2_sens2a_r;
  logic signed [BASE_W-1:0] s2_offb_r;
  logic signed [BASE_W-1:0] s2_sensb_r;
  band_t                    s2_band_r;
  logic [RAW_W-1:0]         s2_d1_r;

  // stage 3: add the frigid band terms
  logic [OFF2_W-1:0]        e2x7;
  logic [OFF2_W-1:0]        off2_nxt;
  logic [SENS2_W-1:0]       sens2_nxt;
  logic [OFF2_W-1:0]        s3_off2_r;
  logic [SENS2_W-1:0]       s3_sens2_r;
  logic signed [BASE_W-1:0] s3_offb_r;
  logic signed [BASE_W-1:0] s3_sensb_r;
  logic signed [TEMP_W-1:0] s3_tf_r;
  logic [RAW_W-1:0]         s3_d1_r;

  // stage 4: final offset and sensitivity
  logic signed [OP_W-1:0]   off_nxt;
  logic signed [OP_W-1:0]   sens_nxt;
  logic signed [OP_W-1:0]   s4_off_r;
  logic signed [OP_W-1:0]   s4_sens_r;
  logic signed [TEMP_W-1:0] s4_tf_r;
  logic [RAW_W-1:0]         s4_d1_r;

  // stage 5: split product sens * d1
  logic [PLO_W-1:0]         plo_nxt;
  logic signed [PHI_W-1:0]  phi_nxt;
  logic [PLO_W-1:0]         s5_plo_r;
  logic signed [PHI_W-1:0]  s5_phi_r;
  logic signed [OP_W-1:0]   s5_off_r;
  logic signed [TEMP_W-1:0] s5_tf_r;

  // stage 6: merge partial products
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] s6_prod_r;
  logic signed [OP_W-1:0]   s6_off_r;
  logic signed [TEMP_W-1:0] s6_tf_r;

  // stage 7: truncating divide by 2^21
  logic signed [PROD_W-1:0] prod_bias;
  logic signed [Q1_W-1:0]   s7_q1_r;
  logic signed [OP_W-1:0]   s7_off_r;
  logic signed [TEMP_W-1:0] s7_tf_r;

  // stage 8: subtract offset
  logic signed [DIFF_W-1:0] diff_nxt;
  logic signed [DIFF_W-1:0] s8_diff_r;
  logic signed [TEMP_W-1:0] s8_tf_r;

  // output: truncating divide by 2^15, saturate
  logic signed [DIFF_W-1:0] diff_bias;
  logic signed [Q2_W-1:0]   q2;
  logic signed [PRES_W-1:0] pres_nxt;
  logic signed [TEMP_W-1:0] out_temp_r;
  logic signed [PRES_W-1:0] out_pres_r;

  // the whole back end advances together when the output slot frees up
  assign en  = !out_valid_r || out_ch.ready;
  assign pop = en && !q_stat.empty;

  assign dt2_full  = $signed(head.dt) * $signed(head.dt);
  assign dd2_full  = $signed(head.dd) * $signed(head.dd);
  assign e_nxt     = E_W'($signed(head.dd)) + E_W'(TEMP_REF + FRIGID_REF);
  assign offt_nxt  = $signed({1'b0, cal.c4}) * $signed(head.dt);
  assign senst_nxt = $signed({1'b0, cal.c3}) * $signed(head.dt);

  assign e2_full = s1_e_r * s1_e_r;
  assign t2_cold = {1'b0, s1_dt2_r[DT2_W-1:33], 1'b0} + {2'b0, s1_dt2_r[DT2_W-1:33]};
  assign dt2x7   = {s1_dt2_r, 3'b0} - {3'b0, s1_dt2_r};
  assign t2      = (s1_band_r == BAND_HOT) ? {3'b0, dt2x7[DT2_W+2:37]} : t2_cold;
  assign temp    = TEMP_W'(s1_dd_r) + TEMP_W'(TEMP_REF);
  assign tf_full = (TEMP_W + 1)'(temp) - $signed({3'b0, t2});

  always_comb begin
    if (tf_full > TEMP_MAX) begin
      tf_nxt = TEMP_W'(TEMP_MAX);
    end else if (tf_full < TEMP_MIN) begin
      tf_nxt = TEMP_W'(TEMP_MIN);
    end else begin
      tf_nxt = tf_full[TEMP_W-1:0];
    end
  end

  assign dd2x3 = {1'b0, s1_dd2_r, 1'b0} + {2'b0, s1_dd2_r};
  assign dd2x5 = {1'b0, s1_dd2_r, 2'b0} + {3'b0, s1_dd2_r};

  always_comb begin
    case (s1_band_r)
      BAND_HOT: begin
        off2a_nxt  = {5'b0, s1_dd2_r[DD2_W-1:4]};
        sens2a_nxt = '0;
      end
      BAND_COLD, BAND_FRIGID: begin
        off2a_nxt  = dd2x3[DD2_W+1:1];
        sens2a_nxt = dd2x5[DD2_W+2:3];
      end
      default: begin
        off2a_nxt  = '0;
        sens2a_nxt = '0;
      end
    endcase
  end

  assign offb_nxt  = $signed({5'b0, cal.c2, 16'b0}) + BASE_W'(s1_offt_r >>> 7);
  assign sensb_nxt = $signed({6'b0, cal.c1, 15'b0}) + BASE_W'(s1_senst_r >>> 8);

  assign e2x7      = {s2_e2_r, 3'b0} - {3'b0, s2_e2_r};
  assign off2_nxt  = {2'b0, s2_off2a_r} + ((s2_band_r == BAND_FRIGID) ? e2x7 : '0);
  assign sens2_nxt = {2'b0, s2_sens2a_r}
                   + ((s2_band_r == BAND_FRIGID) ? {s2_e2_r, 2'b0} : '0);

  assign off_nxt  = OP_W'(s3_offb_r) - $signed({2'b0, s3_off2_r});
  assign sens_nxt = OP_W'(s3_sensb_r) - $signed({3'b0, s3_sens2_r});

  assign plo_nxt = s4_sens_r[SPLIT-1:0] * s4_d1_r;
  assign phi_nxt = $signed(s4_sens_r[OP_W-1:SPLIT]) * $signed({1'b0, s4_d1_r});

  assign prod_nxt = (PROD_W'(s5_phi_r) <<< SPLIT) + $signed({{(PROD_W-PLO_W){1'b0}}, s5_plo_r});

  // bias negative values so the shift truncates toward zero
  assign prod_bias = s6_prod_r + $signed({{Q1_W{1'b0}}, {P_SHIFT{s6_prod_r[PROD_W-1]}}});

  assign diff_nxt = DIFF_W'(s7_q1_r) - DIFF_W'(s7_off_r);

  assign diff_bias = s8_diff_r + $signed({{Q2_W{1'b0}}, {O_SHIFT{s8_diff_r[DIFF_W-1]}}});
  assign q2        = diff_bias[DIFF_W-1:O_SHIFT];

  always_comb begin
    if (q2 > PRES_MAX) begin
      pres_nxt = PRES_W'(PRES_MAX);
    end else if (q2 < PRES_MIN) begin
      pres_nxt = PRES_W'(PRES_MIN);
    end else begin
      pres_nxt = q2[PRES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NSTG-2:0], pop};
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dt2_r    <= dt2_full[DT2_W-1:0];
      s1_dd2_r    <= dd2_full[DD2_W-1:0];
      s1_e_r      <= e_nxt;
      s1_offt_r   <= offt_nxt;
      s1_senst_r  <= senst_nxt;
      s1_dd_r     <= head.dd;
      s1_band_r   <= head.band;
      s1_d1_r     <= head.d1;

      s2_e2_r     <= e2_full[E2_W-1:0];
      s2_tf_r     <= tf_nxt;
      s2_off2a_r  <= off2a_nxt;
      s2_sens2a_r <= sens2a_nxt;
      s2_offb_r   <= offb_nxt;
      s2_sensb_r  <= sensb_nxt;
      s2_band_r   <= s1_band_r;
      s2_d1_r     <= s1_d1_r;

      s3_off2_r   <= off2_nxt;
      s3_sens2_r  <= sens2_nxt;
      s3_offb_r   <= s2_offb_r;
      s3_sensb_r  <= s2_sensb_r;
      s3_tf_r     <= s2_tf_r;
      s3_d1_r     <= s2_d1_r;

      s4_off_r    <= off_nxt;
      s4_sens_r   <= sens_nxt;
      s4_tf_r     <= s3_tf_r;
      s4_d1_r     <= s3_d1_r;

      s5_plo_r    <= plo_nxt;
      s5_phi_r    <= phi_nxt;
      s5_off_r    <= s4_off_r;
      s5_tf_r     <= s4_tf_r;

      s6_prod_r   <= prod_nxt;
      s6_off_r    <= s5_off_r;
      s6_tf_r     <= s5_tf_r;

      s7_q1_r     <= prod_bias[PROD_W-1:P_SHIFT];
      s7_off_r    <= s6_off_r;
      s7_tf_r     <= s6_tf_r;

      s8_diff_r   <= diff_nxt;
      s8_tf_r     <= s7_tf_r;

      out_temp_r  <= s8_tf_r;
      out_pres_r  <= pres_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.temperature_centi = out_temp_r;
  assign out_ch.pressure_value    = out_pres_r;

endmodule

// ----- src/pressure_sensor_compensation_core.sv -----
// Channel  Dir  Payload                                         Handshake
// in_ch    in   raw_temperature, raw_pressure (24b unsigned)    valid / ready
// out_ch   out  temperature_centi (19b s), pressure_value (26b s) valid / ready
// cfg_*    in   cfg_index (3b), cfg_data (16b)                  cfg_we, never stalls
//
// One transaction per cycle in and out unless a channel stalls; from accept to
// out_ch.valid a transaction passes two front stages, one queue slot, eight back
// stages and the output register. The back multiplier stages set that depth.
// rst_n is synchronous: clears valid flags, queue pointers and calibration words.
// The back end holds while out_ch.valid is high and out_ch.ready is low; the front
// keeps accepting until the queue (QUEUE_DEPTH entries) is full.
module pressure_sensor_compensation_core #(
  parameter int QUEUE_DEPTH = pscc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pscc_in_if.sink                        in_ch,
  pscc_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [pscc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pscc_pkg::CAL_W-1:0]     cfg_data
);
  import pscc_pkg::*;

  cal_t    cal;
  q_stat_t q_stat;
  task_t   push_data;
  task_t   head;
  logic    push;
  logic    pop;

  pscc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal)
  );

  pscc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cal       (cal),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  pscc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  pscc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cal    (cal),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ----- src/pscc_checker.sv -----
// Port-level checker for the compensation core, attached by bind.
// Depends on pscc_pkg and the assertion macro header.
`include "pressure_sensor_compensation_core_macros.svh"

module pscc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pscc_pkg::TEMP_W-1:0] out_temp,
  input logic [pscc_pkg::PRES_W-1:0] out_pres
);
  import pscc_pkg::*;

  logic [31:0]              in_cnt_r;
  logic [31:0]              out_cnt_r;
  logic [31:0]              pending;
  logic                     out_stall;
  logic [TEMP_W+PRES_W-1:0] out_payload;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r  <= '0;
      out_cnt_r <= '0;
    end else begin
      if (in_valid && in_ready) begin
        in_cnt_r <= in_cnt_r + 1'b1;
      end
      if (out_valid && out_ready) begin
        out_cnt_r <= out_cnt_r + 1'b1;
      end
    end
  end

  assign pending     = in_cnt_r - out_cnt_r;
  assign out_stall   = out_valid && !out_ready;
  assign out_payload = {out_temp, out_pres};

  `PSCC_ASSERT_RST(a_reset_idle, clk, !rst_n, !out_valid && in_ready)
  `PSCC_ASSERT_IMP(a_no_invented, clk, rst_n, out_valid, pending != '0)
  `PSCC_ASSERT_IMP(a_ready_when_drained, clk, rst_n, pending == '0, in_ready)
  `PSCC_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_payload))

endmodule

bind pressure_sensor_compensation_core pscc_checker u_pscc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_temp  (out_ch.temperature_centi),
  .out_pres  (out_ch.pressure_value)
);
